FILE: sv/fsp_pkg.sv
// Shared types, character codes and lookup functions for the format
// specifier parser. Used by the parser core, the top level and the testbench.
`default_nettype none

package fsp_pkg;

  localparam int FIELD_W = 16;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PCT   = 3'd1,
    PH_FLAGS = 3'd2,
    PH_WIDTH = 3'd3,
    PH_WSTAR = 3'd4,
    PH_DOT   = 3'd5,
    PH_PREC  = 3'd6,
    PH_PSTAR = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_PLAIN = 3'd0,
    ST_IN    = 3'd1,
    ST_PCT   = 3'd2,
    ST_DONE  = 3'd3,
    ST_REJ   = 3'd4
  } status_t;

  // Bit positions of the flags in the flag vector.
  localparam int FL_PLUS  = 0;
  localparam int FL_SPACE = 1;
  localparam int FL_MINUS = 2;
  localparam int FL_ZERO  = 3;
  localparam int FL_QUOTE = 4;
  localparam int FL_HASH  = 5;
  localparam int NUM_FLAGS = 6;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_HASH  = 8'h23;

  typedef struct packed {
    status_t                     status;
    logic [2:0]                  conv_type;
    logic [NUM_FLAGS-1:0]        flags;
    logic                        has_dot;
    logic [FIELD_W-1:0]          width_value;
    logic [FIELD_W-1:0]          prec_value;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } lookup_t;

  function automatic lookup_t flag_lookup(input logic [7:0] c);
    lookup_t r;
    r.hit = 1'b1;
    r.idx = 3'(FL_PLUS);
    case (c)
      CH_PLUS:  r.idx = 3'(FL_PLUS);
      CH_SPACE: r.idx = 3'(FL_SPACE);
      CH_MINUS: r.idx = 3'(FL_MINUS);
      CH_ZERO:  r.idx = 3'(FL_ZERO);
      CH_QUOTE: r.idx = 3'(FL_QUOTE);
      CH_HASH:  r.idx = 3'(FL_HASH);
      default:  r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // Conversion codes follow the order c s p d i u x X.
  function automatic lookup_t conv_lookup(input logic [7:0] c);
    lookup_t r;
    r.hit = 1'b1;
    r.idx = 3'd0;
    case (c)
      8'h63:   r.idx = 3'd0;
      8'h73:   r.idx = 3'd1;
      8'h70:   r.idx = 3'd2;
      8'h64:   r.idx = 3'd3;
      8'h69:   r.idx = 3'd4;
      8'h75:   r.idx = 3'd5;
      8'h78:   r.idx = 3'd6;
      8'h58:   r.idx = 3'd7;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/fsp_ifs.sv
// Valid/ready channel interfaces for format characters and parse results.
// Depends on nothing beyond the fixed field widths.
`default_nettype none

interface fsp_char_if;
  logic               valid;
  logic               ready;
  logic [7:0]         ch;
  logic signed [31:0] star_arg;

  modport source (output valid, ch, star_arg, input ready);
  modport sink   (input valid, ch, star_arg, output ready);
endinterface

interface fsp_spec_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  conv_type;
  logic        flag_plus;
  logic        flag_space;
  logic        flag_minus;
  logic        flag_zero;
  logic        flag_quote;
  logic        flag_hash;
  logic        has_dot;
  logic [15:0] width_value;
  logic [15:0] prec_value;

  modport source (output valid, status, conv_type, flag_plus, flag_space, flag_minus,
                  flag_zero, flag_quote, flag_hash, has_dot, width_value, prec_value,
                  input ready);
  modport sink   (input valid, status, conv_type, flag_plus, flag_space, flag_minus,
                  flag_zero, flag_quote, flag_hash, has_dot, width_value, prec_value,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/format_spec_parser.sv
// Format specifier parser: one format character in, one parse result out per
// character. Each character is held in an input register, parsed in a single
// pass of combinational logic against the parser state, and the result lands
// in an output register. The block takes one character every cycle while the
// output is not stalled; the rate is set by the parser state, which is updated
// once for each character that is parsed. A stalled output
// holds one result while one more character waits in the input register.
// Width and precision saturate at 2^NUM_BITS-1, never above 65535.
`default_nettype none

module format_spec_parser import fsp_pkg::*; #(
  parameter int NUM_BITS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  fsp_char_if.sink    chars,
  fsp_spec_if.source  specs
);

  logic               in_valid;
  logic [7:0]         ch_q;
  logic signed [31:0] star_q;
  logic               out_valid;
  result_t            res_q;
  result_t            res;
  logic               advance;
  logic               step;

  assign advance     = !out_valid || specs.ready;
  assign step        = in_valid && advance;
  assign chars.ready = !in_valid || advance;

  fsp_core #(.NUM_BITS(NUM_BITS)) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .ch       (ch_q),
    .star_arg (star_q),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (chars.ready) in_valid <= chars.valid;
      if (advance) out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      ch_q   <= chars.ch;
      star_q <= chars.star_arg;
    end
    if (step) res_q <= res;
  end

  assign specs.valid       = out_valid;
  assign specs.status      = res_q.status;
  assign specs.conv_type   = res_q.conv_type;
  assign specs.flag_plus   = res_q.flags[FL_PLUS];
  assign specs.flag_space  = res_q.flags[FL_SPACE];
  assign specs.flag_minus  = res_q.flags[FL_MINUS];
  assign specs.flag_zero   = res_q.flags[FL_ZERO];
  assign specs.flag_quote  = res_q.flags[FL_QUOTE];
  assign specs.flag_hash   = res_q.flags[FL_HASH];
  assign specs.has_dot     = res_q.has_dot;
  assign specs.width_value = res_q.width_value;
  assign specs.prec_value  = res_q.prec_value;

`ifndef SYNTHESIS
  // Input backpressure only when both pipeline registers are full.
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !chars.ready |-> (in_valid && out_valid && !specs.ready))
    else $error("input stalled without a full pipeline");

  // Detail fields carry data only on a completed specifier.
  a_zero_unless_done: assert property (@(posedge clk) disable iff (rst)
    (specs.valid && specs.status != ST_DONE) |->
      (specs.width_value == 16'd0 && specs.prec_value == 16'd0 && !specs.has_dot &&
       specs.conv_type == 3'd0 && !specs.flag_plus && !specs.flag_hash))
    else $error("detail fields set on a result that is not a completed specifier");

  a_plus_space: assert property (@(posedge clk) disable iff (rst)
    specs.valid |-> !(specs.flag_plus && specs.flag_space))
    else $error("space flag left set next to plus flag");

  a_zero_fix: assert property (@(posedge clk) disable iff (rst)
    (specs.valid && specs.flag_zero) |->
      (!specs.has_dot && !specs.flag_minus && specs.width_value != 16'd0))
    else $error("zero flag survived correction");

  // A held result must not be overwritten by the next parse step.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !specs.ready) |=> $stable(res_q))
    else $error("stalled result register changed");
`endif

endmodule

`default_nettype wire

FILE: sv/fsp_core.sv
// Parser state and per-character transition logic of the specifier parser.
// Depends on fsp_pkg for phases, status codes and character lookups.
`default_nettype none

module fsp_core import fsp_pkg::*; #(
  parameter int NUM_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic [7:0]         ch,
  input  wire logic signed [31:0] star_arg,
  output result_t                 res
);

  // Accumulators never exceed the saturation limit, so they need no more bits.
  localparam int ACC_W = (NUM_BITS < FIELD_W) ? NUM_BITS : FIELD_W;

  phase_t               phase, phase_next;
  logic [NUM_FLAGS-1:0] flag_bits, flag_bits_next;
  logic [ACC_W-1:0]     width_acc, width_acc_next;
  logic [ACC_W-1:0]     prec_acc, prec_acc_next;
  logic                 dot_seen, dot_seen_next;

  function automatic logic [ACC_W-1:0] add_digit(input logic [ACC_W-1:0] acc,
                                                  input logic [3:0] d);
    logic [ACC_W+3:0] v;
    v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + (ACC_W+4)'(d);
    if (v[ACC_W+3:ACC_W] != 4'd0) return '1;
    return v[ACC_W-1:0];
  endfunction

  function automatic logic [ACC_W-1:0] star_value(input logic signed [31:0] raw);
    if (raw[31]) return '0;
    if (raw[30:ACC_W] != '0) return '1;
    return raw[ACC_W-1:0];
  endfunction

  lookup_t    fl, cv;
  logic       is_digit, is_nz_digit;
  logic [3:0] dval;
  status_t    st;
  logic [NUM_FLAGS-1:0] fix;

  assign fl          = flag_lookup(ch);
  assign cv          = conv_lookup(ch);
  assign is_digit    = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_nz_digit = (ch >= CH_ONE) && (ch <= CH_NINE);
  assign dval        = ch[3:0];

  always_comb begin
    phase_next     = phase;
    flag_bits_next = flag_bits;
    width_acc_next = width_acc;
    prec_acc_next  = prec_acc;
    dot_seen_next  = dot_seen;
    st             = ST_IN;
    case (phase)
      PH_IDLE: begin
        if (ch == CH_PCT) begin
          phase_next     = PH_PCT;
          flag_bits_next = '0;
          width_acc_next = '0;
          prec_acc_next  = '0;
          dot_seen_next  = 1'b0;
        end else begin
          st = ST_PLAIN;
        end
      end
      PH_PCT, PH_FLAGS: begin
        if (phase == PH_PCT && ch == CH_PCT) begin
          st         = ST_PCT;
          phase_next = PH_IDLE;
        end else if (fl.hit) begin
          flag_bits_next[fl.idx] = 1'b1;
          phase_next             = PH_FLAGS;
        end else if (is_nz_digit) begin
          width_acc_next = add_digit('0, dval);
          phase_next     = PH_WIDTH;
        end else if (ch == CH_STAR) begin
          width_acc_next = star_value(star_arg);
          phase_next     = PH_WSTAR;
        end else if (ch == CH_DOT) begin
          dot_seen_next = 1'b1;
          phase_next    = PH_DOT;
        end else if (cv.hit) begin
          st = ST_DONE;
        end else begin
          st = ST_REJ;
        end
      end
      PH_WIDTH: begin
        if (is_digit) begin
          width_acc_next = add_digit(width_acc, dval);
        end else if (ch == CH_DOT) begin
          dot_seen_next = 1'b1;
          phase_next    = PH_DOT;
        end else if (cv.hit) begin
          st = ST_DONE;
        end else begin
          st = ST_REJ;
        end
      end
      PH_WSTAR: begin
        if (ch == CH_DOT) begin
          dot_seen_next = 1'b1;
          phase_next    = PH_DOT;
        end else if (cv.hit) begin
          st = ST_DONE;
        end else begin
          st = ST_REJ;
        end
      end
      PH_DOT: begin
        if (is_digit) begin
          prec_acc_next = add_digit('0, dval);
          phase_next    = PH_PREC;
        end else if (ch == CH_STAR) begin
          prec_acc_next = star_value(star_arg);
          phase_next    = PH_PSTAR;
        end else if (cv.hit) begin
          st = ST_DONE;
        end else begin
          st = ST_REJ;
        end
      end
      PH_PREC: begin
        if (is_digit) begin
          prec_acc_next = add_digit(prec_acc, dval);
        end else if (cv.hit) begin
          st = ST_DONE;
        end else begin
          st = ST_REJ;
        end
      end
      default: begin
        if (cv.hit) st = ST_DONE;
        else        st = ST_REJ;
      end
    endcase
    if (st == ST_DONE || st == ST_REJ) phase_next = PH_IDLE;
  end

  // Flag correction uses the state as it stood before the conversion character.
  always_comb begin
    fix = flag_bits;
    if (fix[FL_PLUS]) fix[FL_SPACE] = 1'b0;
    if (dot_seen || fix[FL_MINUS] || width_acc == '0) fix[FL_ZERO] = 1'b0;
  end

  always_comb begin
    res        = '0;
    res.status = st;
    if (st == ST_DONE) begin
      res.conv_type   = cv.idx;
      res.flags       = fix;
      res.has_dot     = dot_seen;
      res.width_value = FIELD_W'(width_acc);
      res.prec_value  = FIELD_W'(prec_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      flag_bits <= '0;
      width_acc <= '0;
      prec_acc  <= '0;
      dot_seen  <= 1'b0;
    end else if (step) begin
      phase     <= phase_next;
      flag_bits <= flag_bits_next;
      width_acc <= width_acc_next;
      prec_acc  <= prec_acc_next;
      dot_seen  <= dot_seen_next;
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for format_spec_parser: streams format characters
// in, predicts every parse result and checks them in order.
// Depends on fsp_pkg, the channel interfaces in fsp_ifs.sv and the RTL.

module tb_top import fsp_pkg::*; ();

  localparam int NUM_BITS = 16;
  localparam longint SAT_MAX = (NUM_BITS >= 16) ? 65535 : (longint'(1) << NUM_BITS) - 1;
  localparam string FLAG_CHARS = "+ -0'#";  // order matches the FL_* bit positions
  localparam string CONV_CHARS = "cspdiuxX";  // order matches the conversion codes
  localparam int TARGET_ITEMS = 500;
  localparam int HOLD_CYCLES = 64;

  typedef struct {
    logic [7:0]         ch;
    logic signed [31:0] arg;
  } char_item_t;

  logic clk;
  logic rst;

  fsp_char_if char_bus ();
  fsp_spec_if spec_bus ();

  format_spec_parser #(.NUM_BITS(NUM_BITS)) uut (
    .clk   (clk),
    .rst   (rst),
    .chars (char_bus),
    .specs (spec_bus)
  );

  char_item_t pending_chars[$];
  result_t    expected_results[$];
  char_item_t next_char;
  result_t    want;
  int         failures = 0;
  int         chars_in = 0;
  int         total_chars = 0;
  int         hold_at = 0;
  int         hold_cnt;
  bit         hold_done;
  int         send_pct;
  int         recv_pct;

  // Shadow copy of the parser state.
  phase_t             scan_phase = PH_IDLE;
  logic [NUM_FLAGS-1:0] seen_flags = '0;
  logic [15:0]        width_count = '0;
  logic [15:0]        prec_count = '0;
  logic               dot_flag = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("format_spec_parser test failed");
    $finish;
  end

  function automatic logic [15:0] clamp_count(input longint v);
    if (v < 0) return 16'd0;
    if (v > SAT_MAX) return 16'(SAT_MAX);
    return 16'(v);
  endfunction

  // Advances the shadow state by one character and returns the result it causes.
  function automatic result_t parse_char(input logic [7:0] c, input logic signed [31:0] arg);
    result_t r;
    int fidx;
    int cidx;
    logic is_digit;
    logic [NUM_FLAGS-1:0] f;
    r = '0;
    r.status = ST_IN;
    fidx = -1;
    cidx = -1;
    for (int i = 0; i < NUM_FLAGS; i++) if (c == FLAG_CHARS[i]) fidx = i;
    for (int i = 0; i < 8; i++) if (c == CONV_CHARS[i]) cidx = i;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    case (scan_phase)
      PH_IDLE: begin
        if (c == CH_PCT) begin
          scan_phase = PH_PCT;
          seen_flags = '0;
          width_count = '0;
          prec_count = '0;
          dot_flag = 1'b0;
        end else begin
          r.status = ST_PLAIN;
        end
      end
      PH_PCT, PH_FLAGS: begin
        if (scan_phase == PH_PCT && c == CH_PCT) begin
          r.status = ST_PCT;
          scan_phase = PH_IDLE;
        end else if (fidx >= 0) begin
          seen_flags[fidx] = 1'b1;
          scan_phase = PH_FLAGS;
        end else if (c >= CH_ONE && c <= CH_NINE) begin
          width_count = clamp_count(longint'(c - CH_ZERO));
          scan_phase = PH_WIDTH;
        end else if (c == CH_STAR) begin
          width_count = clamp_count(longint'(arg));
          scan_phase = PH_WSTAR;
        end else if (c == CH_DOT) begin
          dot_flag = 1'b1;
          scan_phase = PH_DOT;
        end else if (cidx >= 0) begin
          r.status = ST_DONE;
        end else begin
          r.status = ST_REJ;
        end
      end
      PH_WIDTH: begin
        if (is_digit) begin
          width_count = clamp_count(longint'(width_count) * 10 + longint'(c - CH_ZERO));
        end else if (c == CH_DOT) begin
          dot_flag = 1'b1;
          scan_phase = PH_DOT;
        end else if (cidx >= 0) begin
          r.status = ST_DONE;
        end else begin
          r.status = ST_REJ;
        end
      end
      PH_WSTAR: begin
        if (c == CH_DOT) begin
          dot_flag = 1'b1;
          scan_phase = PH_DOT;
        end else if (cidx >= 0) begin
          r.status = ST_DONE;
        end else begin
          r.status = ST_REJ;
        end
      end
      PH_DOT: begin
        if (is_digit) begin
          prec_count = clamp_count(longint'(c - CH_ZERO));
          scan_phase = PH_PREC;
        end else if (c == CH_STAR) begin
          prec_count = clamp_count(longint'(arg));
          scan_phase = PH_PSTAR;
        end else if (cidx >= 0) begin
          r.status = ST_DONE;
        end else begin
          r.status = ST_REJ;
        end
      end
      PH_PREC: begin
        if (is_digit) begin
          prec_count = clamp_count(longint'(prec_count) * 10 + longint'(c - CH_ZERO));
        end else if (cidx >= 0) begin
          r.status = ST_DONE;
        end else begin
          r.status = ST_REJ;
        end
      end
      default: begin
        if (cidx >= 0) r.status = ST_DONE;
        else r.status = ST_REJ;
      end
    endcase
    if (r.status == ST_DONE) begin
      f = seen_flags;
      if (f[FL_PLUS]) f[FL_SPACE] = 1'b0;
      if (dot_flag || f[FL_MINUS] || width_count == 0) f[FL_ZERO] = 1'b0;
      r.conv_type = 3'(cidx);
      r.flags = f;
      r.has_dot = dot_flag;
      r.width_value = width_count;
      r.prec_value = prec_count;
      scan_phase = PH_IDLE;
    end else if (r.status == ST_REJ) begin
      scan_phase = PH_IDLE;
    end
    return r;
  endfunction

  task automatic push_char(input logic [7:0] c, input logic signed [31:0] arg);
    pending_chars.push_back(char_item_t'{c, arg});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], $urandom);
  endtask

  function automatic logic signed [31:0] rand_star_arg();
    case ($urandom_range(0, 6))
      0: return $urandom;
      1: return $urandom_range(0, 100);
      2: return 32'sh7fffffff;
      3: return 32'sh80000000;
      4: return 0 - $urandom_range(1, 10);
      5: return $urandom_range(65530, 65540);
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  // One specifier with random flags, width and precision. A broken one has a
  // single character after the '%' replaced by a random byte.
  task automatic push_spec(input bit broken);
    char_item_t s[$];
    int pos;
    s.push_back(char_item_t'{CH_PCT, $urandom});
    repeat ($urandom_range(0, 4)) s.push_back(char_item_t'{FLAG_CHARS[$urandom_range(0, 5)],
                                                           $urandom});
    case ($urandom_range(0, 3))
      1: begin
        s.push_back(char_item_t'{8'(CH_ONE + $urandom_range(0, 8)), $urandom});
        repeat ($urandom_range(0, 5))
          s.push_back(char_item_t'{8'(CH_ZERO + $urandom_range(0, 9)), $urandom});
      end
      2: s.push_back(char_item_t'{CH_STAR, rand_star_arg()});
      default: ;
    endcase
    case ($urandom_range(0, 3))
      1: s.push_back(char_item_t'{CH_DOT, $urandom});
      2: begin
        s.push_back(char_item_t'{CH_DOT, $urandom});
        repeat ($urandom_range(1, 5))
          s.push_back(char_item_t'{8'(CH_ZERO + $urandom_range(0, 9)), $urandom});
      end
      3: begin
        s.push_back(char_item_t'{CH_DOT, $urandom});
        s.push_back(char_item_t'{CH_STAR, rand_star_arg()});
      end
      default: ;
    endcase
    s.push_back(char_item_t'{CONV_CHARS[$urandom_range(0, 7)], $urandom});
    if (broken) begin
      pos = $urandom_range(1, s.size() - 1);
      s[pos].ch = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    end
    foreach (s[i]) pending_chars.push_back(s[i]);
  endtask

  // Idle rates by progress: sender light and receiver heavy, then swapped,
  // then full rate for the last third.
  always_comb begin
    if (chars_in < total_chars / 3) begin
      send_pct = 14;
      recv_pct = 49;
    end else if (chars_in < 2 * total_chars / 3) begin
      send_pct = 49;
      recv_pct = 14;
    end else begin
      send_pct = 0;
      recv_pct = 0;
    end
  end

  // One long receiver hold-off during the full-rate third, so the parser
  // fills up and pushes back on its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && chars_in >= hold_at) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      char_bus.valid <= 1'b0;
    end else begin
      if (char_bus.valid && char_bus.ready) begin
        expected_results.push_back(parse_char(char_bus.ch, char_bus.star_arg));
        chars_in <= chars_in + 1;
      end
      if (!char_bus.valid || char_bus.ready) begin
        if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
          next_char = pending_chars.pop_front();
          char_bus.valid <= 1'b1;
          char_bus.ch <= next_char.ch;
          char_bus.star_arg <= next_char.arg;
        end else begin
          char_bus.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      spec_bus.ready <= 1'b0;
    end else begin
      if (spec_bus.valid && spec_bus.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: status %0d", spec_bus.status);
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, spec_bus.status);
          check_field("conv_type", want.conv_type, spec_bus.conv_type);
          check_field("flag_plus", want.flags[FL_PLUS], spec_bus.flag_plus);
          check_field("flag_space", want.flags[FL_SPACE], spec_bus.flag_space);
          check_field("flag_minus", want.flags[FL_MINUS], spec_bus.flag_minus);
          check_field("flag_zero", want.flags[FL_ZERO], spec_bus.flag_zero);
          check_field("flag_quote", want.flags[FL_QUOTE], spec_bus.flag_quote);
          check_field("flag_hash", want.flags[FL_HASH], spec_bus.flag_hash);
          check_field("has_dot", want.has_dot, spec_bus.has_dot);
          check_field("width_value", want.width_value, spec_bus.width_value);
          check_field("prec_value", want.prec_value, spec_bus.prec_value);
        end
      end
      spec_bus.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= recv_pct);
    end
  end

  initial begin
    rst = 1'b1;
    char_bus.valid = 1'b0;
    char_bus.ch = 8'h00;
    char_bus.star_arg = 32'sd0;
    spec_bus.ready = 1'b0;

    // Directed: NUL as plain text, literal percent, every flag with the
    // plus/space and minus/zero corrections, star width with a negative
    // argument and star precision with the largest one, width saturation,
    // star after width digits, and NUL inside a specifier.
    push_char(8'h00, $urandom);
    push_text("%%");
    push_text("%+ -0'#c");
    push_char(CH_PCT, $urandom);
    push_char(CH_STAR, -32'sd7);
    push_char(CH_DOT, $urandom);
    push_char(CH_STAR, 32'sh7fffffff);
    push_text("s");
    push_text("%70000d");
    push_text("%1*");
    push_text("%");
    push_char(8'h00, $urandom);

    while (pending_chars.size() < TARGET_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1: push_char(8'($urandom_range(0, 255)), $urandom);
        2: push_text("%%");
        3, 4, 5: push_spec(1'b1);
        default: push_spec(1'b0);
      endcase
    end
    total_chars = pending_chars.size();
    hold_at = 2 * total_chars / 3 + 20;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() != 0 || char_bus.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("format_spec_parser test passed");
    end else begin
      $display("format_spec_parser test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/fsp_pkg.sv
sv/fsp_ifs.sv
sv/fsp_core.sv
sv/format_spec_parser.sv
dv/tb_top.sv
